// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check that a trigger is followed by a condition in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mbk_pkg.sv =====
// ----------------------------------------------------------------------------
// mbk_pkg
// Types, codes and the default code table of the Morse beacon keyer.
// ----------------------------------------------------------------------------
`default_nettype none

package mbk_pkg;

    localparam int CODE_DEPTH = 64;
    localparam int CODE_AW    = 6;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_MSG  = 2'd1;
    localparam logic [1:0] KIND_CODE = 2'd2;

    localparam logic [7:0] CHAR_LO   = 8'h20;
    localparam logic [7:0] CHAR_HI   = 8'h5F;
    localparam logic [7:0] CODE_END  = 8'h01;
    localparam logic [7:0] CODE_NONE = 8'hFF;

    localparam logic [2:0] PHC_RESET = 3'd0;
    localparam logic [2:0] PHC_CHAR  = 3'd1;
    localparam logic [2:0] PHC_ELEM  = 3'd2;
    localparam logic [2:0] PHC_DASH1 = 3'd3;
    localparam logic [2:0] PHC_DASH2 = 3'd4;
    localparam logic [2:0] PHC_DASH3 = 3'd5;

    typedef enum logic [5:0] {
        PH_RESET = 6'b000001,
        PH_CHAR  = 6'b000010,
        PH_ELEM  = 6'b000100,
        PH_DASH1 = 6'b001000,
        PH_DASH2 = 6'b010000,
        PH_DASH3 = 6'b100000
    } phase_t;

    typedef struct packed {
        logic               rd_en;
        logic [CODE_AW-1:0] rd_idx;
        logic               wr_en;
        logic [CODE_AW-1:0] wr_idx;
        logic [7:0]         wr_data;
    } code_req_t;

    localparam logic [7:0] MORSE_TABLE [CODE_DEPTH] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h6A, 8'h29, 8'h3F, 8'h3E, 8'h3C, 8'h38,
        8'h30, 8'h20, 8'h21, 8'h23, 8'h27, 8'h2F, 8'hFF, 8'hFF, 8'hFF, 8'h31,
        8'hFF, 8'h4C, 8'hFF, 8'h06, 8'h11, 8'h15, 8'h09, 8'h02, 8'h14, 8'h0B,
        8'h10, 8'h04, 8'h1E, 8'h0D, 8'h12, 8'h07, 8'h05, 8'h0F, 8'h16, 8'h1B,
        8'h0A, 8'h08, 8'h03, 8'h0C, 8'h18, 8'h0E, 8'h19, 8'h1D, 8'h13, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF
    };

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_RESET: code = PHC_RESET;
            PH_CHAR:  code = PHC_CHAR;
            PH_ELEM:  code = PHC_ELEM;
            PH_DASH1: code = PHC_DASH1;
            PH_DASH2: code = PHC_DASH2;
            PH_DASH3: code = PHC_DASH3;
            default:  code = PHC_RESET;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mbk_code_store.sv =====
// ----------------------------------------------------------------------------
// mbk_code_store
// Writable code table: one RAM with per-entry valid bits; an entry never
// written reads as the default Morse table. Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mbk_code_store (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mbk_pkg::code_req_t req,
    output logic [7:0]             rdata
);
    import mbk_pkg::*;

    logic [7:0]            code_mem [CODE_DEPTH];
    logic [CODE_DEPTH-1:0] vld_reg;
    logic [7:0]            ram_q_reg;
    logic [7:0]            tab_q_reg;
    logic                  vld_q_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            code_mem[req.wr_idx] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            ram_q_reg <= code_mem[req.rd_idx];
            tab_q_reg <= MORSE_TABLE[req.rd_idx];
            vld_q_reg <= vld_reg[req.rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (req.wr_en)
        begin
            vld_reg[req.wr_idx] <= 1'b1;
        end
    end

    assign rdata = vld_q_reg ? ram_q_reg : tab_q_reg;

    `ASSERT_NEXT(a_wr_sets_valid, req.wr_en, vld_reg[$past(req.wr_idx)],
        "code table write did not mark its entry valid")

endmodule

`default_nettype wire

// ===== hw/rtl/morse_beacon_keyer_core.sv =====
// An accepted word is held in the input stage registers and its result word is
// then written into the output register when the word executes.
// Throughput: one word per cycle while the output is not stalled, with registered
// message and code RAM reads, the next read address forwarded from the state update.
// Reset: asynchronous; no clearing pass, the code table reads as the default
// Morse table until an entry is written, the message RAM is undefined.
// ----------------------------------------------------------------------------
// morse_beacon_keyer_core
// Looping Morse beacon keyer: message RAM, code table RAM and a tick-driven
// keying state machine with a registered result word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module morse_beacon_keyer_core #(
    parameter int MSG_DEPTH = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] kind,
    input  wire logic [5:0] addr,
    input  wire logic [7:0] wdata,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            key_on,
    output logic [2:0]      phase,
    output logic [5:0]      char_pos
);
    import mbk_pkg::*;

    localparam int MSG_AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int XW     = (MSG_AW > 6) ? MSG_AW : 6;

    logic [7:0]        msg_mem [MSG_DEPTH];

    logic              s1_valid_reg, s1_valid_next;
    logic [1:0]        s1_kind_reg;
    logic [5:0]        s1_addr_reg;
    logic [7:0]        s1_wdata_reg;
    logic [7:0]        msg_q_reg;
    logic              mbyp_reg;
    logic [7:0]        mbyp_data_reg;

    phase_t            phase_reg, phase_next;
    logic [MSG_AW-1:0] ptr_reg, ptr_next;
    logic [7:0]        code_shift_reg, code_shift_next;
    logic              code_pend_reg, code_pend_next;
    logic              key_reg, key_next;

    logic              out_valid_reg, out_valid_next;
    logic              key_on_reg;
    logic [2:0]        phase_out_reg;
    logic [5:0]        char_pos_reg;

    logic              exec;
    logic              accept;
    logic [7:0]        ch;
    logic              ch_in_range;
    logic [7:0]        cs_cur;
    logic [7:0]        code_rdata;
    code_req_t         code_req;
    logic              msg_we;
    logic [XW-1:0]     addr_x;
    logic [MSG_AW-1:0] msg_widx;
    logic [XW-1:0]     ptr_x;

    mbk_code_store u_code_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (code_req),
        .rdata (code_rdata)
    );

    assign exec     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !exec;
    assign accept   = in_valid && !in_stall;

    assign ch          = mbyp_reg ? mbyp_data_reg : msg_q_reg;
    assign ch_in_range = (ch >= CHAR_LO) && (ch <= CHAR_HI);
    assign cs_cur      = code_pend_reg ? code_rdata : code_shift_reg;
    assign addr_x      = XW'(s1_addr_reg);
    assign msg_widx    = addr_x[MSG_AW-1:0];
    assign msg_we      = exec && (s1_kind_reg == KIND_MSG)
                         && (32'(s1_addr_reg) < 32'(MSG_DEPTH));
    assign ptr_x       = XW'(ptr_next);

    always_comb
    begin
        phase_next       = phase_reg;
        ptr_next         = ptr_reg;
        code_shift_next  = cs_cur;
        code_pend_next   = 1'b0;
        key_next         = key_reg;
        code_req.rd_en   = 1'b0;
        code_req.rd_idx  = CODE_AW'(ch - CHAR_LO);
        code_req.wr_en   = exec && (s1_kind_reg == KIND_CODE);
        code_req.wr_idx  = s1_addr_reg;
        code_req.wr_data = s1_wdata_reg;

        if (exec && (s1_kind_reg == KIND_TICK))
        begin
            case (phase_reg)
                PH_RESET:
                begin
                    key_next   = 1'b0;
                    ptr_next   = '0;
                    phase_next = PH_CHAR;
                end
                PH_CHAR:
                begin
                    key_next = 1'b0;
                    ptr_next = (ptr_reg == MSG_AW'(MSG_DEPTH - 1)) ? '0
                                                                   : ptr_reg + MSG_AW'(1);
                    if (ch == 8'h00)
                    begin
                        phase_next = PH_RESET;
                    end
                    else
                    begin
                        phase_next = PH_ELEM;
                        if (ch_in_range)
                        begin
                            code_req.rd_en = 1'b1;
                            code_pend_next = 1'b1;
                        end
                        else
                        begin
                            code_shift_next = CODE_NONE;
                        end
                    end
                end
                PH_ELEM:
                begin
                    key_next = 1'b0;
                    if ((cs_cur == CODE_END) || (cs_cur == CODE_NONE))
                    begin
                        phase_next = PH_CHAR;
                    end
                    else
                    begin
                        code_shift_next = {1'b0, cs_cur[7:1]};
                        phase_next      = cs_cur[0] ? PH_DASH1 : PH_DASH3;
                    end
                end
                PH_DASH1:
                begin
                    key_next   = 1'b1;
                    phase_next = PH_DASH2;
                end
                PH_DASH2:
                begin
                    key_next   = 1'b1;
                    phase_next = PH_DASH3;
                end
                PH_DASH3:
                begin
                    key_next   = 1'b1;
                    phase_next = PH_ELEM;
                end
                default:
                begin
                    phase_next = PH_RESET;
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_valid_reg && !exec);
        out_valid_next = exec ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_RESET;
            ptr_reg        <= '0;
            code_shift_reg <= '0;
            code_pend_reg  <= 1'b0;
            key_reg        <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            phase_reg      <= phase_next;
            ptr_reg        <= ptr_next;
            code_shift_reg <= code_shift_next;
            code_pend_reg  <= code_pend_next;
            key_reg        <= key_next;
        end
    end

    // message RAM: write from the executing word, read at the forwarded pointer
    always_ff @(posedge clk)
    begin
        if (msg_we)
        begin
            msg_mem[msg_widx] <= s1_wdata_reg;
        end
        if (accept)
        begin
            msg_q_reg     <= msg_mem[ptr_next];
            mbyp_reg      <= msg_we && (msg_widx == ptr_next);
            mbyp_data_reg <= s1_wdata_reg;
            s1_kind_reg   <= kind;
            s1_addr_reg   <= addr;
            s1_wdata_reg  <= wdata;
        end
        if (exec)
        begin
            key_on_reg    <= key_next;
            phase_out_reg <= phase_code(phase_next);
            char_pos_reg  <= ptr_x[5:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign key_on    = key_on_reg;
    assign phase     = phase_out_reg;
    assign char_pos  = char_pos_reg;

    `ASSERT_ALWAYS(a_stall_only_when_busy, !in_stall || s1_valid_reg,
        "input stalled with no word in flight")
    `ASSERT_ALWAYS(a_pend_in_elem, !code_pend_reg || (phase_reg == PH_ELEM),
        "code lookup pending outside element fetch")
    `ASSERT_ALWAYS(a_key_off_phases,
        !key_reg || !((phase_reg == PH_RESET) || (phase_reg == PH_CHAR)
                      || (phase_reg == PH_DASH1)),
        "key on in a phase that must follow a key-off tick")
    `ASSERT_ALWAYS(a_ptr_in_range, 32'(ptr_reg) < 32'(MSG_DEPTH),
        "message pointer beyond message depth")

endmodule

`default_nettype wire

// ===== tb/morse_beacon_keyer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_beacon_keyer_core_tb
// Self-checking bench for the Morse beacon keyer core. A queue of words feeds
// a driver at the falling edge, a predictor tracks the keying state machine,
// the message and the code table, and a monitor compares every result word
// with the oldest prediction. Directed words cover dots, dashes, skipped and
// out-of-range characters, restart and ignored words. Later phases cover
// message wrap, table rewrites, endless dots and sender and receiver idling.
// ----------------------------------------------------------------------------
module morse_beacon_keyer_core_tb;

    import mbk_pkg::*;

    localparam int         MSG_LEN    = 64;
    localparam int         IDLE_LIMIT = 3000;
    localparam int         LONG_HOLD  = 120;
    localparam logic [1:0] KIND_NONE  = 2'd3;
    localparam logic [7:0] CH_E       = 8'h45;
    localparam logic [7:0] CH_T       = 8'h54;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] addr;
        logic [7:0] wdata;
    } keyer_word_t;

    typedef struct packed {
        logic       key;
        logic [2:0] ph;
        logic [5:0] pos;
    } key_state_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [1:0] kind      = '0;
    logic [5:0] addr      = '0;
    logic [7:0] wdata     = '0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       key_on;
    logic [2:0] phase;
    logic [5:0] char_pos;

    keyer_word_t pending_words [$];
    key_state_t  expected_keys [$];

    logic [7:0] msg_tab  [MSG_LEN];
    logic [7:0] code_tab [CODE_DEPTH];
    logic [2:0] fsm_ph    = PHC_RESET;
    logic [5:0] msg_ptr   = '0;
    logic [7:0] shift_reg = '0;
    logic       key_lvl   = 1'b0;

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic long_hold_req = 1'b0;
    int   hold_left     = 0;
    logic in_fire       = 1'b0;
    int   idle_cycles   = 0;
    int   err_count     = 0;

    morse_beacon_keyer_core #(
        .MSG_DEPTH(MSG_LEN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .addr     (addr),
        .wdata    (wdata),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .key_on   (key_on),
        .phase    (phase),
        .char_pos (char_pos)
    );

    always #5 clk = ~clk;

    task automatic advance_keyer(input keyer_word_t w);
        logic [7:0] ch;
        logic [7:0] idx;
        key_state_t res;
        begin
            if (w.kind == KIND_TICK) begin
                case (fsm_ph)
                    PHC_RESET:
                    begin
                        key_lvl = 1'b0;
                        msg_ptr = '0;
                        fsm_ph  = PHC_CHAR;
                    end
                    PHC_CHAR:
                    begin
                        key_lvl = 1'b0;
                        ch      = msg_tab[msg_ptr];
                        msg_ptr = msg_ptr + 6'd1;
                        if (ch == 8'h00) begin
                            fsm_ph = PHC_RESET;
                        end else begin
                            if (ch < CHAR_LO || ch > CHAR_HI) begin
                                shift_reg = CODE_NONE;
                            end else begin
                                idx       = ch - CHAR_LO;
                                shift_reg = code_tab[idx[5:0]];
                            end
                            fsm_ph = PHC_ELEM;
                        end
                    end
                    PHC_ELEM:
                    begin
                        key_lvl = 1'b0;
                        if (shift_reg == CODE_END || shift_reg == CODE_NONE) begin
                            fsm_ph = PHC_CHAR;
                        end else begin
                            fsm_ph    = shift_reg[0] ? PHC_DASH1 : PHC_DASH3;
                            shift_reg = shift_reg >> 1;
                        end
                    end
                    PHC_DASH1:
                    begin
                        key_lvl = 1'b1;
                        fsm_ph  = PHC_DASH2;
                    end
                    PHC_DASH2:
                    begin
                        key_lvl = 1'b1;
                        fsm_ph  = PHC_DASH3;
                    end
                    PHC_DASH3:
                    begin
                        key_lvl = 1'b1;
                        fsm_ph  = PHC_ELEM;
                    end
                    default:
                    begin
                        fsm_ph = PHC_RESET;
                    end
                endcase
            end else if (w.kind == KIND_MSG) begin
                msg_tab[w.addr] = w.wdata;
            end else if (w.kind == KIND_CODE) begin
                code_tab[w.addr] = w.wdata;
            end
            res.key = key_lvl;
            res.ph  = fsm_ph;
            res.pos = msg_ptr;
            expected_keys.push_back(res);
        end
    endtask

    task automatic queue_word(input logic [1:0] k, input logic [5:0] a, input logic [7:0] d);
        keyer_word_t w;
        begin
            w.kind  = k;
            w.addr  = a;
            w.wdata = d;
            pending_words.push_back(w);
        end
    endtask

    function automatic logic [7:0] pick_char(input logic allow_zero);
        int r;
        begin
            r = $urandom_range(99);
            if (allow_zero && r < 5)
                return 8'h00;
            else if (r < 50)
                return 8'($urandom_range(8'h30, 8'h5A));
            else if (r < 70)
                return 8'($urandom_range(CHAR_LO, CHAR_HI));
            else if (r < 80)
                return 8'($urandom_range(8'h60, 8'hFF));
            else if (r < 90)
                return 8'($urandom_range(8'h01, 8'h1F));
            else
                return CH_SPACE;
        end
    endfunction

    // zero code bytes lock the keyer into endless dots, so keep them out here
    function automatic logic [7:0] pick_code();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 10)
                return CODE_END;
            else if (r < 20)
                return CODE_NONE;
            else
                return 8'($urandom_range(8'h01, 8'hFF));
        end
    endfunction

    task automatic queue_random(input int n, input logic allow_zero);
        int r;
        begin
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(99);
                if (r < 3)
                    queue_word(KIND_NONE, 6'($urandom_range(63)), 8'($urandom_range(255)));
                else if (r < 75)
                    queue_word(KIND_TICK, 6'($urandom_range(63)), 8'($urandom_range(255)));
                else if (r < 88)
                    queue_word(KIND_MSG, 6'($urandom_range(63)), pick_char(allow_zero));
                else
                    queue_word(KIND_CODE, 6'($urandom_range(63)), pick_code());
            end
        end
    endtask

    task automatic wait_idle();
        begin
            while (pending_words.size() != 0 || in_valid || expected_keys.size() != 0)
                @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
            advance_keyer({kind, addr, wdata});
    end

    always @(negedge clk or negedge rst_n)
    begin : drive_words
        keyer_word_t w;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                kind     <= w.kind;
                addr     <= w.addr;
                wdata    <= w.wdata;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (long_hold_req) begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : check_words
        key_state_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_keys.size() == 0) begin
                $error("result word with no prediction: key_on %0d phase %0d char_pos %0d",
                       key_on, phase, char_pos);
                err_count++;
            end else begin
                want = expected_keys.pop_front();
                if (key_on !== want.key) begin
                    $error("key_on: expected %0d, got %0d", want.key, key_on);
                    err_count++;
                end
                if (phase !== want.ph) begin
                    $error("phase: expected %0d, got %0d", want.ph, phase);
                    err_count++;
                end
                if (char_pos !== want.pos) begin
                    $error("char_pos: expected %0d, got %0d", want.pos, char_pos);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        foreach (code_tab[i])
            code_tab[i] = MORSE_TABLE[i];
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: ignored word, dot, skips, table hit, dot-dash, restart
        queue_word(KIND_NONE, 6'd63, 8'hFF);
        queue_word(KIND_MSG, 6'd0, CH_E);
        queue_word(KIND_MSG, 6'd1, 8'h1F);
        queue_word(KIND_MSG, 6'd2, 8'h60);
        queue_word(KIND_MSG, 6'd3, CH_SPACE);
        queue_word(KIND_MSG, 6'd4, CHAR_HI);
        queue_word(KIND_MSG, 6'd5, 8'h00);
        queue_word(KIND_CODE, 6'd63, 8'h06);
        repeat (21) queue_word(KIND_TICK, 6'($urandom_range(63)), 8'($urandom_range(255)));

        // fill the rest of the message with no restart so the pointer wraps
        for (int i = 6; i < MSG_LEN; i++)
            queue_word(KIND_MSG, 6'(i), pick_char(1'b0));
        queue_word(KIND_MSG, 6'd5, pick_char(1'b0));
        queue_random(450, 1'b0);
        wait_idle();

        send_idle_pct = 82;
        queue_random(350, 1'b1);
        wait_idle();

        send_idle_pct = 0;
        stall_pct     = 82;
        long_hold_req = 1'b1;
        queue_random(350, 1'b1);
        wait_idle();

        send_idle_pct = 29;
        stall_pct     = 29;
        queue_random(400, 1'b1);
        wait_idle();

        // zero code byte: endless dots from here on
        send_idle_pct = 0;
        stall_pct     = 0;
        for (int i = 0; i < MSG_LEN; i++)
            queue_word(KIND_MSG, 6'(i), (i % 2 == 0) ? CH_E : CH_T);
        queue_word(KIND_CODE, 6'(CH_E - CHAR_LO), 8'h00);
        queue_word(KIND_CODE, 6'(CH_T - CHAR_LO), 8'h00);
        repeat (80) queue_word(KIND_TICK, 6'($urandom_range(63)), 8'($urandom_range(255)));
        wait_idle();

        repeat (5) @(posedge clk);
        if (expected_keys.size() != 0) begin
            $error("%0d predicted result words never arrived", expected_keys.size());
            err_count++;
        end
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mbk_pkg.sv
hw/rtl/mbk_code_store.sv
hw/rtl/morse_beacon_keyer_core.sv
tb/morse_beacon_keyer_core_tb.sv
